/* src/crcwf_pkg.sv */
// ----------------------------------------------------------------------------
// crcwf_pkg: shared types, constants and CRC functions
// Holds the CRC-32 polynomial, item geometry, queue entry type and the
// bit-level XOR network functions used by the front and back parts.
// ----------------------------------------------------------------------------
package crcwf_pkg;

	// Item geometry: requested byte count, clamped to the 1..16 a word holds
	localparam int ItemBytesReq = 16;
	localparam int ItemBytes    = (ItemBytesReq > 16) ? 16 :
	                              ((ItemBytesReq < 1) ? 1 : ItemBytesReq);
	localparam int WordBytes    = 16;
	localparam int WordBits     = 8 * WordBytes;
	localparam int CntW         = 5;

	localparam logic [31:0] CrcPoly = 32'h04C11DB7;

	// Depth of the queue between front and back
	localparam int QueueDepth = 2;

	typedef logic [CntW-1:0] cnt_t;

	// One classified transaction waiting for the back part
	typedef struct packed {
		logic [31:0] part;    // data contribution, seed folded in when first
		cnt_t        nbytes;  // counted bytes, 0..ItemBytes
		logic        first;
		logic        last;
	} crcwf_entry_t;

	// Advance a CRC through nbits zero bits (nbits constant at each call)
	function automatic logic [31:0] crc_zero_bits(input logic [31:0] c, input int nbits);
		logic [31:0] r;
		r = c;
		for (int i = 0; i < WordBits; i++) begin
			if (i < nbits) begin
				r = {r[30:0], 1'b0} ^ (r[31] ? CrcPoly : 32'h0);
			end
		end
		return r;
	endfunction

	// Advance a CRC through n zero bytes, n selected among 0..ItemBytes
	function automatic logic [31:0] crc_adv(input logic [31:0] c, input cnt_t n);
		logic [31:0] r;
		r = c;
		for (int k = 0; k <= ItemBytes; k++) begin
			if (n == CntW'(k)) begin
				r = crc_zero_bits(c, 8 * k);
			end
		end
		return r;
	endfunction

	// CRC of a full word from a zero register, MSB first
	function automatic logic [31:0] crc_data(input logic [WordBits-1:0] d);
		logic [31:0] r;
		logic        fb;
		r = 32'h0;
		for (int i = WordBits - 1; i >= 0; i--) begin
			fb = r[31] ^ d[i];
			r  = {r[30:0], 1'b0} ^ (fb ? CrcPoly : 32'h0);
		end
		return r;
	endfunction

endpackage

/* src/crcwf_if.sv */
// ----------------------------------------------------------------------------
// crcwf_if: stream channels of the CRC block
// Input channel carries one 16-byte message item per transaction; output
// channel carries one CRC value per finished message.
// ----------------------------------------------------------------------------
interface crcwf_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_high;
	logic [63:0] data_low;
	logic [4:0]  valid_bytes;
	logic        first;
	logic [31:0] seed;
	logic        last;

	modport source (
		output valid, data_high, data_low, valid_bytes, first, seed, last,
		input  ready
	);
	modport sink (
		input  valid, data_high, data_low, valid_bytes, first, seed, last,
		output ready
	);
endinterface

interface crcwf_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_value;

	modport source (output valid, crc_value, input ready);
	modport sink (input valid, crc_value, output ready);
endinterface

/* src/crcwf_front.sv */
// ----------------------------------------------------------------------------
// crcwf_front: input classification
// Accepts item transactions, works out the counted byte count, aligns the
// counted bytes and computes their CRC contribution and the seed term.
// ----------------------------------------------------------------------------
module crcwf_front (
	crcwf_in_if.sink              in_ch,
	input  logic                  q_full,
	output logic                  push,
	output crcwf_pkg::crcwf_entry_t entry
);
	import crcwf_pkg::*;

	cnt_t                vb_sat;
	cnt_t                nbytes;
	logic [7:0]          shamt;
	logic [WordBits-1:0] aligned;
	logic [31:0]         dpart;

	// Accept whenever the queue has room
	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	// Count bytes: full item unless last, then saturated valid_bytes
	always_comb begin
		vb_sat = (in_ch.valid_bytes > CntW'(ItemBytes)) ? CntW'(ItemBytes)
		                                                : in_ch.valid_bytes;
		nbytes = in_ch.last ? vb_sat : CntW'(ItemBytes);
	end

	// Right-align counted bytes; leading zeros leave a zero register unchanged
	assign shamt   = {5'(5'd16 - nbytes), 3'b000};
	assign aligned = {in_ch.data_high, in_ch.data_low} >> shamt;
	assign dpart   = crc_data(aligned);

	// Fold the seed in here so the back loop only handles the running value
	always_comb begin
		entry.part   = in_ch.first ? (crc_adv(in_ch.seed, nbytes) ^ dpart) : dpart;
		entry.nbytes = nbytes;
		entry.first  = in_ch.first;
		entry.last   = in_ch.last;
	end

endmodule

/* src/crcwf_queue.sv */
// ----------------------------------------------------------------------------
// crcwf_queue: short queue between front and back
// Register-based FIFO of classified transactions; push and pop may happen
// in the same cycle.
// ----------------------------------------------------------------------------
module crcwf_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  crcwf_pkg::crcwf_entry_t push_entry,
	output logic                    full,
	input  logic                    pop,
	output logic                    head_valid,
	output crcwf_pkg::crcwf_entry_t head_entry
);
	import crcwf_pkg::*;

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntQW = $clog2(QueueDepth + 1);

	crcwf_entry_t     slot_q [QueueDepth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntQW-1:0] count_q;

	assign full       = (count_q == CntQW'(QueueDepth));
	assign head_valid = (count_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/crcwf_back.sv */
// ----------------------------------------------------------------------------
// crcwf_back: running CRC update and result register
// Pops classified transactions, advances the running CRC by the counted
// bytes and places the CRC of each finished message in the output register.
// ----------------------------------------------------------------------------
module crcwf_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  crcwf_pkg::crcwf_entry_t q_entry,
	output logic                    pop,
	crcwf_out_if.source             out_ch
);
	import crcwf_pkg::*;

	logic [31:0] running_crc_q;
	logic [31:0] crc_next;
	logic        out_valid_q;
	logic [31:0] out_crc_q;
	logic        out_free;

	// Output slot is free when empty or being drained this cycle
	assign out_free = !out_valid_q || out_ch.ready;
	assign pop      = q_valid && (!q_entry.last || out_free);

	// Next CRC: seeded entries carry their full value already
	assign crc_next = q_entry.first ? q_entry.part
	                                : (crc_adv(running_crc_q, q_entry.nbytes) ^ q_entry.part);

	// Hold the running CRC between transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				running_crc_q <= crc_next;
			end
			if (pop && q_entry.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture the result of a finished message
	always_ff @(posedge clk) begin
		if (pop && q_entry.last) begin
			out_crc_q <= crc_next;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.crc_value = out_crc_q;

endmodule

/* src/crc32_msb_first_wide_fold_core.sv */
// ----------------------------------------------------------------------------
// crc32_msb_first_wide_fold_core: CRC-32 (0x04C11DB7, MSB first) over
// 16-byte message items, no reflection and no inversion.
//
// Input channel in_ch: one item per transaction. data_high holds the first
// eight bytes (earliest byte in bits 63:56), data_low the next eight. first
// loads the running CRC from seed; last closes the message, and only then
// valid_bytes (saturated at 16) limits the counted leading bytes.
// Output channel out_ch: one crc_value per message, after its last item.
//
// Throughput: one item per cycle while no last item waits on a stalled out_ch,
// set by the CRC advance loop in the back part. A last item passes the queue
// stage, then the output register, before its result is valid.
// Reset clears the running CRC to zero and empties queue and output.
// When out_ch stalls the result holds; items keep flowing until a second
// last item reaches the queue head, then the two-entry queue fills and
// in_ch.ready drops.
// ----------------------------------------------------------------------------
module crc32_msb_first_wide_fold_core (
	input  logic        clk,
	input  logic        arst_n,
	crcwf_in_if.sink    in_ch,
	crcwf_out_if.source out_ch
);
	import crcwf_pkg::*;

	logic         push;
	logic         q_full;
	logic         pop;
	logic         q_valid;
	crcwf_entry_t push_entry;
	crcwf_entry_t q_entry;

	// Classify incoming transactions
	crcwf_front u_front (
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.entry  (push_entry)
	);

	// Decouple front and back
	crcwf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (q_valid),
		.head_entry (q_entry)
	);

	// Update running CRC and deliver results
	crcwf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

/* src/crcwf_checker.sv */
// ----------------------------------------------------------------------------
// crcwf_checker: port-level checks for the CRC block
// Tracks messages closed at the input against results delivered at the
// output and checks stall behavior, the in-flight bound and back-pressure.
// ----------------------------------------------------------------------------
module crcwf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_crc
);
	logic       last_acc;
	logic       out_acc;
	logic [2:0] pending_q;

	assign last_acc = in_valid && in_ready && in_last;
	assign out_acc  = out_valid && out_ready;

	// Count closed messages whose result is not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_acc && !out_acc) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_acc && !last_acc) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	// Stalled result holds its value
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_crc))
		else $error("result changed while stalled");

	// No result without a closed message
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without a closed message");

	// Queue plus output register bound the messages in flight
	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("too many messages in flight");

	// Back-pressure only when results are waiting
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pending_q != 3'd0)
		else $error("input stalled with no pending result");

endmodule

bind crc32_msb_first_wide_fold_core crcwf_checker u_crcwf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_last   (in_ch.last),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_crc   (out_ch.crc_value)
);

/* sim/tb_crc32_msb_first_wide_fold_core.sv */
// ----------------------------------------------------------------------------
// tb_crc32_msb_first_wide_fold_core: self-checking bench for the wide CRC-32
// Sends 16-byte items over in_ch. A directed table comes first: the reset
// value, seed pass-through, catalog check strings, saturated and zero byte
// counts, and multi-item messages. Random messages follow, mostly well
// formed with some stray first/last flags. A bit-serial CRC model predicts
// each crc_value not given by hand, and results are checked in order as
// they leave out_ch. Both channels idle in random bursts. One long output
// stall fills the block, and one pause drains it completely.
// ----------------------------------------------------------------------------
module tb_crc32_msb_first_wide_fold_core;

	// One input transaction
	typedef struct packed {
		logic [63:0] data_high;
		logic [63:0] data_low;
		logic [4:0]  valid_bytes;
		logic        first;
		logic [31:0] seed;
		logic        last;
	} crc_item_t;

	// Directed row: item plus an optional hand-computed CRC
	typedef struct packed {
		crc_item_t   item;
		logic        has_known;
		logic [31:0] known_crc;
	} crc_row_t;

	localparam int NumRows      = 20;
	localparam int RandomItems  = 700;
	localparam int CalmItems    = 80;
	localparam int HoldCycles   = 60;
	localparam int BurstMsgs    = 16;
	localparam int SettleCycles = 20;

	logic clk;
	logic arst_n;

	crcwf_in_if  in_ch();
	crcwf_out_if out_ch();

	crc32_msb_first_wide_fold_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// Model state and scoreboard
	logic [31:0] crc_running;
	logic [31:0] crc_expect_q[$];
	int          error_count;
	int          directed_sent;
	int          random_sent;
	int          results_checked;
	bit          hold_req;
	bit          calm;

	crc_row_t    crc_rows[NumRows];

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

	// Absorb the counted bytes of one item, MSB first
	function automatic logic [31:0] absorb_item(input logic [31:0] start, input crc_item_t it);
		logic [127:0] word;
		logic [31:0]  crc;
		int           count;
		word  = {it.data_high, it.data_low};
		count = crcwf_pkg::ItemBytes;
		if (it.last && int'(it.valid_bytes) < count) begin
			count = int'(it.valid_bytes);
		end
		crc = it.first ? it.seed : start;
		for (int k = 0; k < crcwf_pkg::ItemBytes; k++) begin
			if (k < count) begin
				crc = crc ^ {word[127 - 8*k -: 8], 24'h0};
				for (int b = 0; b < 8; b++) begin
					crc = crc[31] ? ({crc[30:0], 1'b0} ^ crcwf_pkg::CrcPoly)
					              : {crc[30:0], 1'b0};
				end
			end
		end
		return crc;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		$display("MISMATCH %s: got %08h, expected %08h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Offer one transaction, hold it until accepted, then update the model
	task automatic send_item(input crc_item_t it, input bit use_known,
	                         input logic [31:0] known);
		logic [31:0] next_crc;
		in_ch.valid       <= 1'b1;
		in_ch.data_high   <= it.data_high;
		in_ch.data_low    <= it.data_low;
		in_ch.valid_bytes <= it.valid_bytes;
		in_ch.first       <= it.first;
		in_ch.seed        <= it.seed;
		in_ch.last        <= it.last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		next_crc    = absorb_item(crc_running, it);
		crc_running = next_crc;
		if (it.last) begin
			crc_expect_q.push_back(use_known ? known : next_crc);
		end
	endtask

	// Random idle burst on the input side
	task automatic maybe_idle_input();
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 6);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] pick_seed();
		case ($urandom_range(0, 5))
			0:       return 32'h0;
			1:       return 32'hFFFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	// Random message: well formed most of the time, stray flags otherwise
	task automatic send_message(input int len, input bit noisy, input bit gaps);
		crc_item_t it;
		for (int i = 0; i < len; i++) begin
			it.data_high = {$urandom, $urandom};
			it.data_low  = {$urandom, $urandom};
			it.seed      = pick_seed();
			if (noisy) begin
				it.first = 1'($urandom_range(0, 1));
				it.last  = 1'($urandom_range(0, 1));
			end else begin
				it.first = (i == 0);
				it.last  = (i == len - 1);
			end
			if (it.last && $urandom_range(0, 7) != 0) begin
				it.valid_bytes = 5'($urandom_range(1, 16));
			end else begin
				it.valid_bytes = 5'($urandom_range(0, 31));
			end
			send_item(it, 1'b0, 32'h0);
			random_sent++;
			if (gaps) begin
				maybe_idle_input();
			end
		end
	endtask

	// Directed stimulus table
	initial begin
		crc_rows = '{
			// after reset, nothing absorbed: running CRC is zero
			'{'{64'h0, 64'h0, 5'd0, 1'b0, 32'h0, 1'b1}, 1'b1, 32'h00000000},
			// seed passes through when no byte counts
			'{'{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 5'd0, 1'b1,
			    32'hFFFFFFFF, 1'b1}, 1'b1, 32'hFFFFFFFF},
			// zero data over zero seed stays zero
			'{'{64'h0, 64'h0, 5'd16, 1'b1, 32'h0, 1'b1}, 1'b1, 32'h00000000},
			// "123456789" with all-ones seed and with zero seed
			'{'{64'h3132333435363738, 64'h3900000000000000, 5'd9, 1'b1,
			    32'hFFFFFFFF, 1'b1}, 1'b1, 32'h0376E6E7},
			'{'{64'h3132333435363738, 64'h3900000000000000, 5'd9, 1'b1,
			    32'h00000000, 1'b1}, 1'b1, 32'h89A1897F},
			// continue from the previous message without first
			'{'{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 5'd4, 1'b0,
			    32'hDEADBEEF, 1'b1}, 1'b0, 32'h0},
			// byte counts above the item size saturate
			'{'{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 5'd31, 1'b1,
			    32'hFFFFFFFF, 1'b1}, 1'b0, 32'h0},
			'{'{64'h0123456789ABCDEF, 64'hFEDCBA9876543210, 5'd17, 1'b0,
			    32'h0, 1'b1}, 1'b0, 32'h0},
			// three-item message, byte counts on non-last items ignored
			'{'{64'hA5A5A5A5A5A5A5A5, 64'h5A5A5A5A5A5A5A5A, 5'd0, 1'b1,
			    32'h12345678, 1'b0}, 1'b0, 32'h0},
			'{'{64'h8000000000000001, 64'h0000000100000000, 5'd3, 1'b0,
			    32'hFFFFFFFF, 1'b0}, 1'b0, 32'h0},
			'{'{64'hFF00000000000000, 64'h0, 5'd1, 1'b0, 32'h0, 1'b1}, 1'b0, 32'h0},
			// two-item message opening with all-ones data and seed
			'{'{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 5'd31, 1'b1,
			    32'hFFFFFFFF, 1'b0}, 1'b0, 32'h0},
			'{'{64'hAAAAAAAAAAAAAAAA, 64'h5555555555555555, 5'd16, 1'b0,
			    32'h0, 1'b1}, 1'b0, 32'h0},
			// byte counts at the word boundary
			'{'{64'h0102030405060708, 64'h090A0B0C0D0E0F10, 5'd8, 1'b1,
			    32'h80000000, 1'b1}, 1'b0, 32'h0},
			'{'{64'h0102030405060708, 64'h090A0B0C0D0E0F10, 5'd7, 1'b1,
			    32'h00000001, 1'b1}, 1'b0, 32'h0},
			'{'{64'h0102030405060708, 64'h090A0B0C0D0E0F10, 5'd15, 1'b1,
			    32'h7FFFFFFF, 1'b1}, 1'b0, 32'h0},
			// zero bytes on last after a non-last item
			'{'{64'hC3C3C3C3C3C3C3C3, 64'h3C3C3C3C3C3C3C3C, 5'd9, 1'b1,
			    32'hCAFEF00D, 1'b0}, 1'b0, 32'h0},
			'{'{64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF, 5'd0, 1'b0,
			    32'h0, 1'b1}, 1'b0, 32'h0},
			// first in mid-message restarts from the new seed
			'{'{64'h1111111111111111, 64'h2222222222222222, 5'd2, 1'b1,
			    32'h0F0F0F0F, 1'b0}, 1'b0, 32'h0},
			'{'{64'h3333333333333333, 64'h4444444444444444, 5'd12, 1'b1,
			    32'hF0F0F0F0, 1'b1}, 1'b0, 32'h0}
		};
	end

	// Input side: reset, directed table, stall burst, random messages
	initial begin
		int msgs;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.data_high   = 64'h0;
		in_ch.data_low    = 64'h0;
		in_ch.valid_bytes = 5'd0;
		in_ch.first       = 1'b0;
		in_ch.seed        = 32'h0;
		in_ch.last        = 1'b0;
		crc_running       = 32'h0;
		error_count       = 0;
		directed_sent     = 0;
		random_sent       = 0;
		results_checked   = 0;
		hold_req          = 1'b0;
		calm              = 1'b0;
		msgs              = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int r = 0; r < NumRows; r++) begin
			send_item(crc_rows[r].item, crc_rows[r].has_known, crc_rows[r].known_crc);
			directed_sent++;
			maybe_idle_input();
		end

		// Stall the output while single-item messages keep coming
		hold_req = 1'b1;
		for (int m = 0; m < BurstMsgs; m++) begin
			send_message(1, 1'b0, 1'b0);
		end

		// Random messages, drain once midway, no idling near the end
		while (random_sent < RandomItems) begin
			if (msgs == 60) begin
				in_ch.valid <= 1'b0;
				while (crc_expect_q.size() != 0) @(posedge clk);
			end
			if (random_sent >= RandomItems - CalmItems) begin
				calm = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_message($urandom_range(1, 6), 1'b1, 1'b1);
			end else if ($urandom_range(0, 7) == 0) begin
				send_message($urandom_range(5, 10), 1'b0, 1'b1);
			end else begin
				send_message($urandom_range(1, 4), 1'b0, 1'b1);
			end
			msgs++;
		end
		in_ch.valid <= 1'b0;

		// Wait out the remaining results, then a few quiet cycles
		while (crc_expect_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);

		$display("Covered %0d directed and %0d random transactions, %0d CRC values checked,",
		         directed_sent, random_sent, results_checked);
		$display("including a long output stall with a full block and a complete drain pause.");
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Output side: random stall bursts, one long hold-off on request
	initial begin
		int stall_left;
		stall_left   = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ch.ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				if (!calm && stall_left == 0 && $urandom_range(0, 6) == 0) begin
					stall_left = $urandom_range(1, 6);
				end
				out_ch.ready <= (stall_left == 0);
				if (stall_left > 0) begin
					stall_left--;
				end
			end
		end
	end

	// Check each accepted result against the oldest expectation
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (crc_expect_q.size() == 0) begin
				report_mismatch("unexpected crc_value", out_ch.crc_value, 32'h0);
			end else begin
				want = crc_expect_q.pop_front();
				results_checked++;
				if (out_ch.crc_value !== want) begin
					report_mismatch("crc_value", out_ch.crc_value, want);
				end
			end
		end
	end

endmodule
